[rtl/core/bfsa_pkg.sv]
// Package: sizes, command and status codes, and the word search helper of the allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfsa_pkg;

    // Bitmap geometry
    localparam int CAPACITY_BITS = 4096;
    localparam int WORD_BITS     = 64;
    localparam int NUM_WORDS     = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int WBIT_W        = $clog2(WORD_BITS);
    localparam int CUR_W         = ADDR_W + WBIT_W;
    localparam int SPAN_MAX      = CAPACITY_BITS - 1;

    // Field widths
    localparam int VAL_W  = 16;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CIDX_W = 2;

    typedef logic [WORD_BITS-1:0] word_t;

    // Commands
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_PLACE = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_MIN = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX = 2'd1;

    // Position of the lowest zero bit of a word (zero when the word is all ones)
    function automatic logic [WBIT_W-1:0] first_zero(input word_t w);
        logic [WBIT_W-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                p = WBIT_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

[rtl/core/bitmap_free_slot_allocator.sv]
// Top level: free slot bitmap allocator with one word memory and a search cursor.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | in        | in_valid / in_stall   | command, value
//  out     | out       | out_valid / out_stall | status, bit_value, found_value
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// For get, set and clear the accept cycle issues the memory read and the execute
// state then modifies and writes the word back once the result register is free.
// find visits the bitmap words in order; the single read port of the word memory
// allows one word and one priority encode per cycle.
// Reset clears all word valid bits at once, so the bitmap reads as all zeros with
// no clearing pass; a min or max register write clears them again and zeroes the cursor.
// The result register lets the next item be accepted while a result waits; an
// item finishing while the result register is still stalled holds in place.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_free_slot_allocator
    import bfsa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input items
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CMD_W-1:0]  command,
    input  wire logic [VAL_W-1:0]  value,
    // results
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [STAT_W-1:0]      status,
    output logic                   bit_value,
    output logic [VAL_W-1:0]       found_value,
    // configuration writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CIDX_W-1:0] cfg_index,
    input  wire logic [VAL_W-1:0]  cfg_data
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    // Control state
    logic [0:0]           state_reg, state_next;
    logic [CUR_W-1:0]     cursor_reg, cursor_next;
    logic [VAL_W-1:0]     min_reg, min_next;
    logic [VAL_W-1:0]     max_reg, max_next;
    logic [NUM_WORDS-1:0] wvalid_reg, wvalid_next;
    logic                 out_valid_reg, out_valid_next;

    // Item in flight
    logic [CMD_W-1:0]     cmd_reg;
    logic [CUR_W-1:0]     pos_reg, pos_next;
    logic                 bad_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic                 rd_ok_reg;
    word_t                rd_data_reg;

    // Result register
    logic [STAT_W-1:0]    status_reg;
    logic                 bit_reg;
    logic [VAL_W-1:0]     found_reg;

    // Word memory
    word_t                mem [NUM_WORDS];

    logic                 accept, cfg_write, out_free, commit;
    logic [VAL_W:0]       diff_full, off_full;
    logic                 order_bad, below, above;
    logic [CUR_W-1:0]     span;
    logic [ADDR_W-1:0]    last_w, cur_w, rd_addr;
    logic [WBIT_W-1:0]    cur_b, zero_pos;
    word_t                word, low_mask, masked, wr_data;
    logic [CUR_W-1:0]     hit_pos;
    logic                 done, advance, we_req, mem_we, mem_re;
    logic [STAT_W-1:0]    res_status;
    logic                 res_bit;
    logic [VAL_W-1:0]     res_found;
    logic [CUR_W-1:0]     cursor_res;

    assign accept    = in_valid && !in_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // Span of covered offsets, saturated at capacity minus one
    always_comb
    begin
        diff_full = {1'b0, max_reg} - {1'b0, min_reg};
        order_bad = diff_full[VAL_W];
        if (diff_full[VAL_W-1:0] > VAL_W'(SPAN_MAX))
        begin
            span = CUR_W'(SPAN_MAX);
        end
        else
        begin
            span = CUR_W'(diff_full[VAL_W-1:0]);
        end
        last_w = span[CUR_W-1:WBIT_W];
    end

    // Range check of the incoming value
    always_comb
    begin
        off_full = {1'b0, value} - {1'b0, min_reg};
        below    = off_full[VAL_W];
        above    = off_full[VAL_W-1:0] > VAL_W'(span);
        if (command == CMD_FIND)
        begin
            pos_next = cursor_reg;
        end
        else
        begin
            pos_next = CUR_W'(off_full[VAL_W-1:0]);
        end
    end

    // Execute step: work on the word held in the read register
    always_comb
    begin
        word       = rd_ok_reg ? rd_data_reg : '0;
        cur_w      = pos_reg[CUR_W-1:WBIT_W];
        cur_b      = pos_reg[WBIT_W-1:0];
        low_mask   = ~({WORD_BITS{1'b1}} << cur_b);
        masked     = word | low_mask;
        zero_pos   = first_zero(masked);
        hit_pos    = {cur_w, zero_pos};
        done       = 1'b0;
        advance    = 1'b0;
        we_req     = 1'b0;
        wr_data    = word;
        res_status = ST_OK;
        res_bit    = 1'b0;
        res_found  = '0;
        cursor_res = cursor_reg;
        if (bad_reg)
        begin
            done       = 1'b1;
            res_status = ST_BAD;
        end
        else
        begin
            case (cmd_reg)
                CMD_GET:
                begin
                    done    = 1'b1;
                    res_bit = word[cur_b];
                end
                CMD_SET:
                begin
                    done    = 1'b1;
                    we_req  = 1'b1;
                    wr_data = word | (WORD_BITS'(1) << cur_b);
                end
                CMD_CLEAR:
                begin
                    done    = 1'b1;
                    we_req  = 1'b1;
                    wr_data = word & ~(WORD_BITS'(1) << cur_b);
                    if (pos_reg < cursor_reg)
                    begin
                        cursor_res = pos_reg;
                    end
                end
                CMD_FIND:
                begin
                    if (pos_reg > span)
                    begin
                        // cursor beyond the span: answer no place, leave cursor
                        done       = 1'b1;
                        res_status = ST_NO_PLACE;
                    end
                    else if (&word)
                    begin
                        if (cur_w == last_w)
                        begin
                            done       = 1'b1;
                            res_status = ST_NO_PLACE;
                            cursor_res = {cur_w, {WBIT_W{1'b1}}};
                        end
                        else
                        begin
                            advance = 1'b1;
                        end
                    end
                    else if (!(&masked))
                    begin
                        done = 1'b1;
                        if (hit_pos <= span)
                        begin
                            cursor_res = hit_pos;
                            res_found  = VAL_W'(hit_pos) + min_reg;
                        end
                        else
                        begin
                            res_status = ST_NO_PLACE;
                            cursor_res = span;
                        end
                    end
                    else if (cur_w == last_w)
                    begin
                        done       = 1'b1;
                        res_status = ST_NO_PLACE;
                        cursor_res = span;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
    end

    assign commit  = (state_reg == S_EXEC) && done && out_free;
    assign mem_we  = commit && we_req;
    assign mem_re  = accept || ((state_reg == S_EXEC) && advance);
    assign rd_addr = accept ? pos_next[CUR_W-1:WBIT_W] : ADDR_W'(cur_w + 1'b1);

    // Next state of control registers
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        wvalid_next    = wvalid_reg;
        out_valid_next = out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next  = S_IDLE;
                    cursor_next = cursor_res;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (mem_we)
        begin
            wvalid_next[cur_w] = 1'b1;
        end
        // a register write starts a fresh allocation
        if (cfg_write && ((cfg_index == REG_MIN) || (cfg_index == REG_MAX)))
        begin
            if (cfg_index == REG_MIN)
            begin
                min_next = cfg_data;
            end
            else
            begin
                max_next = cfg_data;
            end
            wvalid_next = '0;
            cursor_next = '0;
        end
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            min_reg       <= '0;
            max_reg       <= VAL_W'(4095);
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            wvalid_reg    <= wvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item registers: capture on accept, advance the search pointer a word at a time
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            pos_reg <= pos_next;
            bad_reg <= order_bad || ((command != CMD_FIND) && (below || above));
        end
        else if ((state_reg == S_EXEC) && advance)
        begin
            pos_reg <= {ADDR_W'(cur_w + 1'b1), {WBIT_W{1'b0}}};
        end
        if (commit)
        begin
            status_reg <= res_status;
            bit_reg    <= res_bit;
            found_reg  <= res_found;
        end
    end

    // Word memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[cur_w] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_ok_reg   <= wvalid_reg[rd_addr];
            addr_reg    <= rd_addr;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign bit_value   = bit_reg;
    assign found_value = found_reg;

    // Checks
    a_commit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == S_IDLE))
        else $error("state did not return to idle after a result");

    a_no_write_on_bad: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !bad_reg)
        else $error("bitmap written by a rejected command");

    a_exec_word_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> (addr_reg == cur_w))
        else $error("word in the read register does not match the search pointer");

    a_clear_lowers_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !bad_reg && (cmd_reg == CMD_CLEAR)) |=> (cursor_reg <= $past(pos_reg)))
        else $error("clear left the cursor above the freed slot");

    a_cfg_resets_store: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && ((cfg_index == REG_MIN) || (cfg_index == REG_MAX)))
            |=> ((cursor_reg == '0) && (wvalid_reg == '0)))
        else $error("register write did not clear the bitmap");

endmodule

`default_nettype wire
